// ----- rtl/oeaf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the One Euro adaptive filter.
// Depends on nothing; used by the controller, the datapath and the top level.
package oeaf_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CUTOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_CUTOFF = 2'd2;

  localparam logic [31:0] MIN_CUTOFF_RST  = 32'd65536;
  localparam logic [31:0] SPEED_GAIN_RST  = 32'd0;
  localparam logic [31:0] RATE_CUTOFF_RST = 32'd65536;

  localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;
  localparam logic [35:0] US_SCALE   = 36'd65536000000;
  localparam logic [19:0] US_PER_S   = 20'd1000000;
  localparam logic [47:0] RATE_MAX   = 48'h7FFF_FFFF_FFFF;

  // The raw rate quotient has 52 bits, so its division runs 52 steps.
  localparam logic [CNT_W-1:0] RATE_DIV_LAST = 6'd51;

  typedef enum logic [17:0] {
    ST_IDLE      = 18'h00001,
    ST_INIT      = 18'h00002,
    ST_DIFF      = 18'h00004,
    ST_DIV1_LOAD = 18'h00008,
    ST_DIV       = 18'h00010,
    ST_RAW       = 18'h00020,
    ST_AP        = 18'h00040,
    ST_AMH       = 18'h00080,
    ST_AM        = 18'h00100,
    ST_DIV2_LOAD = 18'h00200,
    ST_ASET      = 18'h00400,
    ST_SMLO      = 18'h00800,
    ST_SMHI      = 18'h01000,
    ST_SMSET     = 18'h02000,
    ST_GLO       = 18'h04000,
    ST_GHI       = 18'h08000,
    ST_FC        = 18'h10000,
    ST_DONE      = 18'h20000
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_DIFF,
    OP_DIV1_LOAD,
    OP_DIV_STEP,
    OP_RAW,
    OP_ALPHA_P,
    OP_ALPHA_MH,
    OP_ALPHA_M,
    OP_DIV2_LOAD,
    OP_ALPHA_SET,
    OP_SM_LO,
    OP_SM_HI,
    OP_SM_SET,
    OP_GAIN_LO,
    OP_GAIN_HI,
    OP_FC,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   main_pass;
  } dp_cmd_t;

  typedef struct packed {
    logic have_history;
  } dp_status_t;

endpackage

// ----- rtl/oeaf_controller.sv -----
`timescale 1ns / 1ps
// Sequencer of the One Euro filter: steps the datapath through one word.
// Depends on oeaf_pkg.
module oeaf_controller #(
  parameter int unsigned ALPHA_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  oeaf_pkg::dp_status_t status_i,
  output oeaf_pkg::dp_cmd_t    cmd_o
);

  oeaf_pkg::state_e state_q, state_d;
  logic [oeaf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic main_q, main_d;
  logic div_alpha_q, div_alpha_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    main_d      = main_q;
    div_alpha_d = div_alpha_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op        = oeaf_pkg::OP_NONE;
    cmd_o.main_pass = main_q;
    unique case (state_q)
      oeaf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = oeaf_pkg::OP_LOAD;
          main_d   = 1'b0;
          state_d  = (in_cmd_i || !status_i.have_history) ? oeaf_pkg::ST_INIT
                                                           : oeaf_pkg::ST_DIFF;
        end
      end
      oeaf_pkg::ST_INIT: begin
        cmd_o.op = oeaf_pkg::OP_INIT;
        state_d  = oeaf_pkg::ST_DONE;
      end
      oeaf_pkg::ST_DIFF: begin
        cmd_o.op = oeaf_pkg::OP_DIFF;
        state_d  = oeaf_pkg::ST_DIV1_LOAD;
      end
      oeaf_pkg::ST_DIV1_LOAD: begin
        cmd_o.op    = oeaf_pkg::OP_DIV1_LOAD;
        cnt_d       = oeaf_pkg::RATE_DIV_LAST;
        div_alpha_d = 1'b0;
        state_d     = oeaf_pkg::ST_DIV;
      end
      oeaf_pkg::ST_DIV: begin
        cmd_o.op = oeaf_pkg::OP_DIV_STEP;
        if (cnt_q == '0) begin
          state_d = div_alpha_q ? oeaf_pkg::ST_ASET : oeaf_pkg::ST_RAW;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      oeaf_pkg::ST_RAW: begin
        cmd_o.op = oeaf_pkg::OP_RAW;
        state_d  = oeaf_pkg::ST_AP;
      end
      oeaf_pkg::ST_AP: begin
        cmd_o.op = oeaf_pkg::OP_ALPHA_P;
        state_d  = oeaf_pkg::ST_AMH;
      end
      oeaf_pkg::ST_AMH: begin
        cmd_o.op = oeaf_pkg::OP_ALPHA_MH;
        state_d  = oeaf_pkg::ST_AM;
      end
      oeaf_pkg::ST_AM: begin
        cmd_o.op = oeaf_pkg::OP_ALPHA_M;
        state_d  = oeaf_pkg::ST_DIV2_LOAD;
      end
      oeaf_pkg::ST_DIV2_LOAD: begin
        cmd_o.op    = oeaf_pkg::OP_DIV2_LOAD;
        cnt_d       = oeaf_pkg::CNT_W'(ALPHA_FRAC_BITS);
        div_alpha_d = 1'b1;
        state_d     = oeaf_pkg::ST_DIV;
      end
      oeaf_pkg::ST_ASET: begin
        cmd_o.op = oeaf_pkg::OP_ALPHA_SET;
        state_d  = oeaf_pkg::ST_SMLO;
      end
      oeaf_pkg::ST_SMLO: begin
        cmd_o.op = oeaf_pkg::OP_SM_LO;
        state_d  = oeaf_pkg::ST_SMHI;
      end
      oeaf_pkg::ST_SMHI: begin
        cmd_o.op = oeaf_pkg::OP_SM_HI;
        state_d  = oeaf_pkg::ST_SMSET;
      end
      oeaf_pkg::ST_SMSET: begin
        cmd_o.op = oeaf_pkg::OP_SM_SET;
        state_d  = main_q ? oeaf_pkg::ST_DONE : oeaf_pkg::ST_GLO;
      end
      oeaf_pkg::ST_GLO: begin
        cmd_o.op = oeaf_pkg::OP_GAIN_LO;
        state_d  = oeaf_pkg::ST_GHI;
      end
      oeaf_pkg::ST_GHI: begin
        cmd_o.op = oeaf_pkg::OP_GAIN_HI;
        state_d  = oeaf_pkg::ST_FC;
      end
      oeaf_pkg::ST_FC: begin
        cmd_o.op = oeaf_pkg::OP_FC;
        main_d   = 1'b1;
        state_d  = oeaf_pkg::ST_AP;
      end
      oeaf_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = oeaf_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = oeaf_pkg::ST_IDLE;
        end
      end
      default: state_d = oeaf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oeaf_pkg::ST_IDLE;
      cnt_q       <= '0;
      main_q      <= 1'b0;
      div_alpha_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      main_q      <= main_d;
      div_alpha_q <= div_alpha_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == oeaf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/oeaf_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the One Euro filter: configuration, filter state, multipliers
// and the shared restoring divider. Depends on oeaf_pkg.
module oeaf_datapath #(
  parameter int unsigned ALPHA_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  oeaf_pkg::dp_cmd_t                 cmd_i,
  output oeaf_pkg::dp_status_t              status_o,
  input  logic                              cfg_we_i,
  input  logic [oeaf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic signed [31:0]                in_sample_value_i,
  input  logic [19:0]                       in_step_time_us_i,
  output logic signed [31:0]                out_filtered_value_o,
  output logic signed [47:0]                out_filtered_rate_o
);

  localparam int unsigned AlphaW = ALPHA_FRAC_BITS + 1;
  localparam logic [AlphaW-1:0] AlphaOne = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
  localparam logic [79:0] AccHalf = 80'(1) << (ALPHA_FRAC_BITS - 1);

  logic [31:0] min_cutoff_q, speed_gain_q, rate_cutoff_q;
  logic        have_q, have_d;
  logic signed [31:0] prev_in_q, prev_in_d, prev_out_q, prev_out_d;
  logic signed [47:0] sr_q, sr_d;

  logic signed [31:0] x_q, x_d;
  logic [19:0]  us_q, us_d;
  logic [79:0]  acc_q, acc_d;
  logic         neg_q, neg_d;
  logic signed [47:0] raw_q, raw_d;
  logic [51:0]  p_q, p_d;
  logic [52:0]  mh_q, mh_d;
  logic [55:0]  m_q, m_d;
  logic [56:0]  rem_q, rem_d, den_q, den_d;
  logic [51:0]  num_q, num_d, quot_q, quot_d;
  logic [AlphaW-1:0] alpha_q, alpha_d;
  logic [47:0]  mag_q, mag_d;
  logic [31:0]  fc_q, fc_d;
  logic signed [31:0] fv_q, fv_d;
  logic signed [47:0] fr_q, fr_d;

  logic signed [32:0] diff;
  logic [31:0]  diff_mag;
  logic [51:0]  diff_prod;
  logic [57:0]  div_t, div_sub;
  logic         div_ge;
  logic [47:0]  raw_sat;
  logic [31:0]  f_sel, f_eff;
  logic [52:0]  pl_prod;
  logic signed [48:0] sm_y, sm_t, sm_diff, sm_step, sm_new;
  logic [47:0]  sm_mag;
  logic [79:0]  rounded;
  logic [46:0]  rmag;
  logic [23:0]  mul_a;
  logic [31:0]  mul_b;
  logic [55:0]  mul_p;
  logic [31:0]  gain;
  logic [32:0]  fc_sum;
  logic         gain_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cutoff_q  <= oeaf_pkg::MIN_CUTOFF_RST;
      speed_gain_q  <= oeaf_pkg::SPEED_GAIN_RST;
      rate_cutoff_q <= oeaf_pkg::RATE_CUTOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        oeaf_pkg::CFG_MIN_CUTOFF:  min_cutoff_q  <= cfg_data_i;
        oeaf_pkg::CFG_SPEED_GAIN:  speed_gain_q  <= cfg_data_i;
        oeaf_pkg::CFG_RATE_CUTOFF: rate_cutoff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    diff      = {x_q[31], x_q} - {prev_in_q[31], prev_in_q};
    diff_mag  = diff[32] ? 32'(-diff) : diff[31:0];
    diff_prod = 52'(diff_mag) * 52'(oeaf_pkg::US_PER_S);

    div_t   = {rem_q, num_q[51]};
    div_ge  = (div_t >= {1'b0, den_q});
    div_sub = div_t - {1'b0, den_q};

    raw_sat = (quot_q > 52'(oeaf_pkg::RATE_MAX)) ? oeaf_pkg::RATE_MAX : quot_q[47:0];

    f_sel   = cmd_i.main_pass ? fc_q : rate_cutoff_q;
    f_eff   = (f_sel == '0) ? 32'd1 : f_sel;
    pl_prod = 53'(p_q[25:0]) * 53'(oeaf_pkg::TWO_PI_Q24);

    sm_y    = cmd_i.main_pass ? 49'(prev_out_q) : 49'(sr_q);
    sm_t    = cmd_i.main_pass ? 49'(x_q) : 49'(raw_q);
    sm_diff = sm_t - sm_y;
    sm_mag  = sm_diff[48] ? 48'(-sm_diff) : sm_diff[47:0];
    rounded = acc_q + AccHalf;
    sm_step = 49'(rounded >> ALPHA_FRAC_BITS);
    sm_new  = neg_q ? (sm_y - sm_step) : (sm_y + sm_step);

    rmag    = sr_q[47] ? 47'(-sr_q) : sr_q[46:0];
    gain_op = (cmd_i.op == oeaf_pkg::OP_GAIN_LO) || (cmd_i.op == oeaf_pkg::OP_GAIN_HI);
    case (cmd_i.op)
      oeaf_pkg::OP_SM_HI:   mul_a = mag_q[47:24];
      oeaf_pkg::OP_GAIN_LO: mul_a = rmag[23:0];
      oeaf_pkg::OP_GAIN_HI: mul_a = {1'b0, rmag[46:24]};
      default:              mul_a = mag_q[23:0];
    endcase
    mul_b = gain_op ? speed_gain_q : 32'(alpha_q);
    mul_p = 56'(mul_a) * 56'(mul_b);

    gain   = (acc_q[79:48] != '0) ? 32'hFFFF_FFFF : acc_q[47:16];
    fc_sum = 33'(min_cutoff_q) + 33'(gain);
  end

  always_comb begin
    have_d     = have_q;
    prev_in_d  = prev_in_q;
    prev_out_d = prev_out_q;
    sr_d       = sr_q;
    x_d        = x_q;
    us_d       = us_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    raw_d      = raw_q;
    p_d        = p_q;
    mh_d       = mh_q;
    m_d        = m_q;
    rem_d      = rem_q;
    den_d      = den_q;
    num_d      = num_q;
    quot_d     = quot_q;
    alpha_d    = alpha_q;
    mag_d      = mag_q;
    fc_d       = fc_q;
    fv_d       = fv_q;
    fr_d       = fr_q;
    case (cmd_i.op) inside
      oeaf_pkg::OP_LOAD: begin
        x_d  = in_sample_value_i;
        us_d = (in_step_time_us_i == '0) ? 20'd1 : in_step_time_us_i;
      end
      oeaf_pkg::OP_INIT: begin
        prev_in_d  = x_q;
        prev_out_d = x_q;
        sr_d       = '0;
        have_d     = 1'b1;
      end
      oeaf_pkg::OP_DIFF: begin
        neg_d = diff[32];
        acc_d = 80'(diff_prod);
      end
      oeaf_pkg::OP_DIV1_LOAD: begin
        rem_d  = '0;
        num_d  = acc_q[51:0];
        den_d  = 57'(us_q);
        quot_d = '0;
      end
      oeaf_pkg::OP_DIV_STEP: begin
        rem_d  = div_ge ? div_sub[56:0] : div_t[56:0];
        num_d  = {num_q[50:0], 1'b0};
        quot_d = {quot_q[50:0], div_ge};
      end
      oeaf_pkg::OP_RAW: begin
        raw_d = neg_q ? -$signed(raw_sat) : $signed(raw_sat);
      end
      oeaf_pkg::OP_ALPHA_P: begin
        p_d = 52'(f_eff) * 52'(us_q);
      end
      oeaf_pkg::OP_ALPHA_MH: begin
        mh_d = 53'(p_q[51:26]) * 53'(oeaf_pkg::TWO_PI_Q24);
      end
      oeaf_pkg::OP_ALPHA_M: begin
        m_d = {1'b0, mh_q, 2'b00} + 56'(pl_prod >> 24);
      end
      oeaf_pkg::OP_DIV2_LOAD: begin
        rem_d  = 57'(oeaf_pkg::US_SCALE >> 1);
        num_d  = '0;
        den_d  = 57'(m_q) + 57'(oeaf_pkg::US_SCALE);
        quot_d = '0;
      end
      oeaf_pkg::OP_ALPHA_SET: begin
        alpha_d = AlphaOne - quot_q[AlphaW-1:0];
        neg_d   = sm_diff[48];
        mag_d   = sm_mag;
      end
      oeaf_pkg::OP_SM_LO, oeaf_pkg::OP_GAIN_LO: begin
        acc_d = 80'(mul_p);
      end
      oeaf_pkg::OP_SM_HI, oeaf_pkg::OP_GAIN_HI: begin
        acc_d = acc_q + (80'(mul_p) << 24);
      end
      oeaf_pkg::OP_SM_SET: begin
        if (cmd_i.main_pass) begin
          prev_out_d = sm_new[31:0];
          prev_in_d  = x_q;
        end else begin
          sr_d = sm_new[47:0];
        end
      end
      oeaf_pkg::OP_FC: begin
        fc_d = fc_sum[32] ? 32'hFFFF_FFFF : fc_sum[31:0];
      end
      oeaf_pkg::OP_OUT: begin
        fv_d = prev_out_q;
        fr_d = sr_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q     <= 1'b0;
      prev_in_q  <= '0;
      prev_out_q <= '0;
      sr_q       <= '0;
    end else begin
      have_q     <= have_d;
      prev_in_q  <= prev_in_d;
      prev_out_q <= prev_out_d;
      sr_q       <= sr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    us_q    <= us_d;
    acc_q   <= acc_d;
    neg_q   <= neg_d;
    raw_q   <= raw_d;
    p_q     <= p_d;
    mh_q    <= mh_d;
    m_q     <= m_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    num_q   <= num_d;
    quot_q  <= quot_d;
    alpha_q <= alpha_d;
    mag_q   <= mag_d;
    fc_q    <= fc_d;
    fv_q    <= fv_d;
    fr_q    <= fr_d;
  end

  assign status_o.have_history = have_q;
  assign out_filtered_value_o  = fv_q;
  assign out_filtered_rate_o   = fr_q;

endmodule

// ----- rtl/one_euro_adaptive_filter_unit.sv -----
`timescale 1ns / 1ps
// Top level of the One Euro adaptive low-pass filter.
// Depends on oeaf_pkg, oeaf_controller and oeaf_datapath.
//
//   channel | direction | handshake           | payload
//   in      | sink      | in_valid/in_ready   | cmd, sample_value, step_time_us
//   out     | source    | out_valid/out_ready | filtered_value, filtered_rate
//   cfg     | sink      | cfg_we              | cfg_index, cfg_data
//
// A filtered word runs the 52-step rate division and the two alpha divisions
// between acceptance and result, each one quotient bit a cycle.
// A reset command, or the first word after reset, runs only the INIT step before its result.
// One word is in work at a time; a new word is taken while the result waits.
// A stalled result holds the sequencer in its last step. No clearing pass.
module one_euro_adaptive_filter_unit #(
  parameter int unsigned ALPHA_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_cmd_i,
  input  logic signed [31:0]             in_sample_value_i,
  input  logic [19:0]                    in_step_time_us_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             out_filtered_value_o,
  output logic signed [47:0]             out_filtered_rate_o,
  input  logic                           cfg_we_i,
  input  logic [oeaf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  oeaf_pkg::dp_cmd_t    dp_cmd;
  oeaf_pkg::dp_status_t dp_status;

  oeaf_controller #(
    .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_cmd_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  oeaf_datapath #(
    .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_sample_value_i   (in_sample_value_i),
    .in_step_time_us_i   (in_step_time_us_i),
    .out_filtered_value_o(out_filtered_value_o),
    .out_filtered_rate_o (out_filtered_rate_o)
  );

endmodule

// ----- rtl/oeaf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the One Euro filter, bound to the top level.
// Depends on one_euro_adaptive_filter_unit.
module oeaf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               in_cmd_i,
  input logic signed [31:0] in_sample_value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] out_filtered_value_o,
  input logic signed [47:0] out_filtered_rate_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Ready stayed high after a word was accepted.");

  a_reset_cmd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_cmd_i && !out_valid_o) |-> ##3
    (out_valid_o && out_filtered_value_o == $past(in_sample_value_i, 3) &&
     out_filtered_rate_o == 48'sd0))
    else $error("A reset command did not return its sample with zero rate.");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("A result appeared while the block was still busy.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_filtered_value_o) &&
    $stable(out_filtered_rate_o)))
    else $error("A stalled result word was dropped or changed.");

endmodule

bind one_euro_adaptive_filter_unit oeaf_checker u_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of one_euro_adaptive_filter_unit: directed table, then random words.
// Depends on oeaf_pkg and the filter RTL; predicts each result with its own fixed-point model.
module tb;

  localparam int unsigned AFB = 16;
  localparam logic [63:0] US_SCALE64 = 64'd65536000000;
  localparam logic [63:0] TWO_PI64 = 64'd105414357;
  localparam longint RATE_LIM = 64'sd140737488355327;
  localparam logic [oeaf_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  typedef struct {
    logic cmd;
    logic [31:0] sample;
    logic [19:0] step;
    logic check_lit;
    logic [31:0] lit_value;
    logic [47:0] lit_rate;
  } stim_row_t;

  typedef struct {
    logic [31:0] value;
    logic [47:0] rate;
  } filt_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic in_cmd_i = 1'b0;
  logic signed [31:0] in_sample_value_i = '0;
  logic [19:0] in_step_time_us_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_filtered_value_o;
  logic signed [47:0] out_filtered_rate_o;
  logic cfg_we_i = 1'b0;
  logic [oeaf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  logic [31:0] min_fc, beta, rate_fc;
  logic seen;
  longint last_in, last_out, rate_acc;
  filt_out_t expected_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  bit recv_hold = 1'b0;

  one_euro_adaptive_filter_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #200ms;
    $display("one_euro_adaptive_filter_unit test failed");
    $finish;
  end

  function automatic logic [63:0] alpha_of(logic [31:0] fc, logic [63:0] us);
    logic [63:0] f, p, m;
    logic [127:0] num;
    f = (fc == 0) ? 64'd1 : {32'd0, fc};
    p = f * us;
    m = (p >> 26) * TWO_PI64 * 4 + (((p & 64'h3FF_FFFF) * TWO_PI64) >> 24);
    num = {64'd0, US_SCALE64} << AFB;
    return (64'd1 << AFB) - 64'(num / {64'd0, m + US_SCALE64});
  endfunction

  function automatic longint lowpass(longint y, longint t, logic [63:0] a);
    logic [63:0] mag, q;
    mag = (t < y) ? 64'(y - t) : 64'(t - y);
    q = (mag >> AFB) * a + (((mag & 64'hFFFF) * a + 64'h8000) >> AFB);
    return (t < y) ? y - longint'(q) : y + longint'(q);
  endfunction

  function automatic filt_out_t filter_word(logic cmd, logic [31:0] s, logic [19:0] st);
    longint x, d, raw;
    logic [63:0] us, mag, q, rmag, gain, fc;
    filt_out_t r;
    x = longint'(signed'(s));
    us = (st == 0) ? 64'd1 : {44'd0, st};
    if (cmd || !seen) begin
      last_in = x;
      last_out = x;
      rate_acc = 0;
      seen = 1'b1;
    end else begin
      d = x - last_in;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      q = mag * 64'd1000000 / us;
      if (q > 64'(RATE_LIM)) q = 64'(RATE_LIM);
      raw = (d < 0) ? -longint'(q) : longint'(q);
      rate_acc = lowpass(rate_acc, raw, alpha_of(rate_fc, us));
      rmag = (rate_acc < 0) ? 64'(-rate_acc) : 64'(rate_acc);
      if (beta == 0) gain = 0;
      else if (rmag > 64'hFFFF_FFFF_FFFF / beta) gain = 64'hFFFF_FFFF;
      else gain = (rmag * beta) >> 16;
      fc = min_fc + gain;
      if (fc > 64'hFFFF_FFFF) fc = 64'hFFFF_FFFF;
      last_out = lowpass(last_out, x, alpha_of(fc[31:0], us));
      last_in = x;
    end
    r.value = last_out[31:0];
    r.rate = rate_acc[47:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", {16'd0, out_filtered_rate_o}, 64'd0);
      end else begin
        filt_out_t e;
        e = expected_q.pop_front();
        if (out_filtered_value_o !== e.value)
          report_mismatch("filtered_value", 64'(out_filtered_value_o), 64'(e.value));
        if (out_filtered_rate_o !== e.rate)
          report_mismatch("filtered_rate", 64'(out_filtered_rate_o), 64'(e.rate));
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(logic [oeaf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == oeaf_pkg::CFG_MIN_CUTOFF) min_fc = data;
    else if (idx == oeaf_pkg::CFG_SPEED_GAIN) beta = data;
    else if (idx == oeaf_pkg::CFG_RATE_CUTOFF) rate_fc = data;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic send_word(logic cmd, logic [31:0] s, logic [19:0] st, ref filt_out_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_cmd_i <= cmd;
    in_sample_value_i <= s;
    in_step_time_us_i <= st;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = filter_word(cmd, s, st);
    expected_q.push_back(r);
  endtask

  task automatic random_word();
    filt_out_t r;
    logic [31:0] s;
    logic [19:0] st;
    logic cmd;
    cmd = ($urandom_range(19) == 0);
    case ($urandom_range(5))
      0: s = $urandom;
      1: s = last_in[31:0] + $urandom_range(4095) - 32'd2048;
      2: s = last_in[31:0] + ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0001);
      default: s = last_in[31:0] + ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
    endcase
    case ($urandom_range(4))
      0: st = 20'($urandom);
      1: st = 20'($urandom_range(3));
      default: st = 20'($urandom_range(20000));
    endcase
    send_word(cmd, s, st, r);
  endtask

  initial begin
    stim_row_t rows[$];
    filt_out_t r;
    int k;
    min_fc = oeaf_pkg::MIN_CUTOFF_RST;
    beta = oeaf_pkg::SPEED_GAIN_RST;
    rate_fc = oeaf_pkg::RATE_CUTOFF_RST;
    seen = 1'b0;
    last_in = 0;
    last_out = 0;
    rate_acc = 0;
    rows = '{
      '{1'b0, 32'h0001_0000, 20'd1000, 1'b1, 32'h0001_0000, 48'd0},
      '{1'b0, 32'h0002_0000, 20'd0, 1'b0, 32'd0, 48'd0},
      '{1'b0, 32'h7FFF_FFFF, 20'd1, 1'b0, 32'd0, 48'd0},
      '{1'b0, 32'h8000_0000, 20'd1, 1'b0, 32'd0, 48'd0},
      '{1'b0, 32'h7FFF_FFFF, 20'hFFFFF, 1'b0, 32'd0, 48'd0},
      '{1'b1, 32'h8000_0000, 20'd5, 1'b1, 32'h8000_0000, 48'd0},
      '{1'b0, 32'h8000_0000, 20'd5, 1'b0, 32'd0, 48'd0},
      '{1'b1, 32'h7FFF_FFFF, 20'hFFFFF, 1'b1, 32'h7FFF_FFFF, 48'd0},
      '{1'b0, 32'h0000_0000, 20'd1000, 1'b0, 32'd0, 48'd0},
      '{1'b0, 32'hFFFF_0000, 20'd1000, 1'b0, 32'd0, 48'd0},
      '{1'b0, 32'h0003_8000, 20'd16667, 1'b0, 32'd0, 48'd0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send_word(rows[i].cmd, rows[i].sample, rows[i].step, r);
      if (rows[i].check_lit && (r.value !== rows[i].lit_value || r.rate !== rows[i].lit_rate))
        report_mismatch("table row", 64'(r.value), 64'(rows[i].lit_value));
    end
    drain();
    write_reg(oeaf_pkg::CFG_SPEED_GAIN, 32'hFFFF_FFFF);
    write_reg(oeaf_pkg::CFG_MIN_CUTOFF, 32'd0);
    write_reg(oeaf_pkg::CFG_RATE_CUTOFF, 32'd0);
    write_reg(CFG_NO_REG, 32'h1234_5678);
    for (k = 0; k < 8; k++) send_word(k[0], $urandom, 20'($urandom), r);
    drain();
    write_reg(oeaf_pkg::CFG_MIN_CUTOFF, 32'hFFFF_FFFF);
    write_reg(oeaf_pkg::CFG_RATE_CUTOFF, 32'hFFFF_FFFF);
    for (k = 0; k < 6; k++) send_word(1'b0, $urandom, 20'($urandom_range(100)), r);
    // Hold the receiver off so the unit backs up and stalls its input.
    recv_hold = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        for (k = 0; k < 4; k++) random_word();
        in_valid_i <= 1'b0;
      end
    join
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 19 : (ph == 1) ? 47 : 0;
      recv_idle = (ph == 0) ? 47 : (ph == 1) ? 19 : 0;
      write_reg(oeaf_pkg::CFG_MIN_CUTOFF, $urandom_range(40, 1) << 16 | $urandom_range(65535));
      write_reg(oeaf_pkg::CFG_SPEED_GAIN, (ph == 2) ? 32'd0 : $urandom_range(65536));
      write_reg(oeaf_pkg::CFG_RATE_CUTOFF, $urandom_range(4, 1) << 16 | $urandom_range(65535));
      for (k = 0; k < 225; k++) begin
        random_word();
        if (k == 100) drain();
      end
      drain();
    end
    if (errors == 0) begin
      $display("one_euro_adaptive_filter_unit test passed");
    end else begin
      $display("one_euro_adaptive_filter_unit test failed");
    end
    $finish;
  end
endmodule

// ----- one_euro_adaptive_filter_unit.f -----
rtl/oeaf_pkg.sv
rtl/oeaf_controller.sv
rtl/oeaf_datapath.sv
rtl/one_euro_adaptive_filter_unit.sv
rtl/oeaf_checker.sv
test/tb.sv
